/* hdl/dsr_pkg.sv */
// ----------------------------------------------------------------------------
// dsr_pkg
// Shared widths and controller/datapath handshake types for the DER ECDSA
// signature to raw r||s converter.
// ----------------------------------------------------------------------------
package dsr_pkg;

    localparam int COMPONENT_BYTES_DEF = 32;
    localparam int SIG_BYTE_W          = 8;
    localparam int RAW_INDEX_W         = 6;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear;       // restart on a first byte
        logic len_load;    // latch an integer length byte
        logic pad_emit;    // emit one zero pad word
        logic val_emit;    // emit the incoming value byte
        logic drop_clear;  // swallow the sign-padding byte
        logic err_emit;    // emit the length error word
    } dsr_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;    // output register can take a word this cycle
        logic len_over;    // length byte above component size + 1
        logic len_full;    // length byte equals component size + 1
        logic len_short;   // length byte below component size
        logic len_zero;    // length byte is zero
        logic pad_last;    // one pad word left
        logic val_last;    // at most one value byte left
        logic drop;        // next value byte is to be dropped
    } dsr_status_t;

endpackage

/* hdl/dsr_sig_if.sv */
// ----------------------------------------------------------------------------
// dsr_sig_if
// Input channel: one DER signature byte per word.
// ----------------------------------------------------------------------------
interface dsr_sig_if
    import dsr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [SIG_BYTE_W-1:0] sig_byte;
    logic                  first_byte;

    modport source (output valid, output sig_byte, output first_byte, input ready);
    modport sink   (input valid, input sig_byte, input first_byte, output ready);
endinterface

/* hdl/dsr_raw_if.sv */
// ----------------------------------------------------------------------------
// dsr_raw_if
// Output channel: one raw r||s byte per word, with position and flags.
// ----------------------------------------------------------------------------
interface dsr_raw_if
    import dsr_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [SIG_BYTE_W-1:0]  raw_byte;
    logic [RAW_INDEX_W-1:0] raw_index;
    logic                   last_out;
    logic                   length_error;

    modport source (output valid, output raw_byte, output raw_index,
                    output last_out, output length_error, input ready);
    modport sink   (input valid, input raw_byte, input raw_index,
                    input last_out, input length_error, output ready);
endinterface

/* hdl/dsr_ctrl.sv */
// ----------------------------------------------------------------------------
// dsr_ctrl
// Parser state machine: walks the DER fields and issues datapath commands.
// ----------------------------------------------------------------------------
module dsr_ctrl
    import dsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_first,
    output logic        in_ready,
    input  dsr_status_t status,
    output dsr_cmd_t    cmd
);

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_SEQLEN = 4'd1;
    localparam logic [3:0] PH_RTAG   = 4'd2;
    localparam logic [3:0] PH_RLEN   = 4'd3;
    localparam logic [3:0] PH_RVAL   = 4'd4;
    localparam logic [3:0] PH_STAG   = 4'd5;
    localparam logic [3:0] PH_SLEN   = 4'd6;
    localparam logic [3:0] PH_SVAL   = 4'd7;
    localparam logic [3:0] PH_PAD    = 4'd8;

    logic [3:0] phase_reg, phase_next;
    logic [3:0] ret_reg, ret_next;
    logic       accept;
    logic [3:0] val_ph, after_ph;

    assign in_ready = (phase_reg != PH_PAD) && status.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        val_ph   = (phase_reg == PH_SLEN || phase_reg == PH_SVAL) ? PH_SVAL : PH_RVAL;
        after_ph = (phase_reg == PH_SLEN || phase_reg == PH_SVAL) ? PH_IDLE : PH_STAG;
    end

    always_comb
    begin
        phase_next = phase_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        if (accept)
        begin
            if (in_first)
            begin
                cmd.clear  = 1'b1;
                phase_next = PH_SEQLEN;
            end
            else
            begin
                case (phase_reg)
                    PH_SEQLEN: phase_next = PH_RTAG;
                    PH_RTAG:   phase_next = PH_RLEN;
                    PH_STAG:   phase_next = PH_SLEN;
                    PH_RLEN, PH_SLEN:
                    begin
                        cmd.len_load = 1'b1;
                        if (status.len_over)
                        begin
                            cmd.err_emit = 1'b1;
                            phase_next   = PH_IDLE;
                        end
                        else if (status.len_short)
                        begin
                            phase_next = PH_PAD;
                            ret_next   = status.len_zero ? after_ph : val_ph;
                        end
                        else
                        begin
                            phase_next = val_ph;
                        end
                    end
                    PH_RVAL, PH_SVAL:
                    begin
                        if (status.drop)
                        begin
                            cmd.drop_clear = 1'b1;
                        end
                        else
                        begin
                            cmd.val_emit = 1'b1;
                            if (status.val_last)
                            begin
                                phase_next = after_ph;
                            end
                        end
                    end
                    default: phase_next = phase_reg;
                endcase
            end
        end
        else if (phase_reg == PH_PAD && status.out_free)
        begin
            cmd.pad_emit = 1'b1;
            if (status.pad_last)
            begin
                phase_next = ret_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            ret_reg   <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

/* hdl/dsr_datapath.sv */
// ----------------------------------------------------------------------------
// dsr_datapath
// Byte counters, drop flag, raw position and the output word register.
// ----------------------------------------------------------------------------
module dsr_datapath
    import dsr_pkg::*;
#(
    parameter int COMPONENT_BYTES = COMPONENT_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [SIG_BYTE_W-1:0]  sig_byte,
    input  dsr_cmd_t               cmd,
    output dsr_status_t            status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SIG_BYTE_W-1:0]  raw_byte,
    output logic [RAW_INDEX_W-1:0] raw_index,
    output logic                   last_out,
    output logic                   length_error
);

    localparam int BW = $clog2(COMPONENT_BYTES + 1);
    localparam int PW = $clog2(2 * COMPONENT_BYTES) + 1;
    localparam logic [SIG_BYTE_W-1:0] LEN_FULL = SIG_BYTE_W'(COMPONENT_BYTES + 1);
    localparam logic [SIG_BYTE_W-1:0] LEN_CB   = SIG_BYTE_W'(COMPONENT_BYTES);
    localparam logic [PW-1:0]         POS_LAST = PW'(2 * COMPONENT_BYTES - 1);
    localparam logic [BW-1:0]         BL_FULL  = BW'(COMPONENT_BYTES);

    logic [BW-1:0]          bytes_left_reg, bytes_left_next;
    logic [BW-1:0]          pad_cnt_reg, pad_cnt_next;
    logic                   drop_reg, drop_next;
    logic [PW-1:0]          pos_reg, pos_next;
    logic                   ovalid_reg, ovalid_next;
    logic [SIG_BYTE_W-1:0]  obyte_reg, obyte_next;
    logic [RAW_INDEX_W-1:0] oindex_reg, oindex_next;
    logic                   olast_reg, olast_next;
    logic                   oerr_reg, oerr_next;
    logic                   emit_data;
    logic                   out_free;
    logic [SIG_BYTE_W-1:0]  pad_len;

    assign out_free  = !ovalid_reg || out_ready;
    assign emit_data = cmd.pad_emit || cmd.val_emit;
    assign pad_len   = LEN_CB - sig_byte;

    always_comb
    begin
        status.out_free  = out_free;
        status.len_over  = sig_byte > LEN_FULL;
        status.len_full  = sig_byte == LEN_FULL;
        status.len_short = sig_byte < LEN_CB;
        status.len_zero  = sig_byte == '0;
        status.pad_last  = pad_cnt_reg == BW'(1);
        status.val_last  = bytes_left_reg <= BW'(1);
        status.drop      = drop_reg;
    end

    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        pad_cnt_next    = pad_cnt_reg;
        drop_next       = drop_reg;
        pos_next        = pos_reg;
        ovalid_next     = ovalid_reg && !out_ready;
        obyte_next      = obyte_reg;
        oindex_next     = oindex_reg;
        olast_next      = olast_reg;
        oerr_next       = oerr_reg;

        if (cmd.clear)
        begin
            bytes_left_next = '0;
            drop_next       = 1'b0;
            pos_next        = '0;
        end

        if (cmd.len_load)
        begin
            if (status.len_over)
            begin
                bytes_left_next = '0;
                drop_next       = 1'b0;
            end
            else if (status.len_full)
            begin
                bytes_left_next = BL_FULL;
                drop_next       = 1'b1;
            end
            else
            begin
                // length fits the component here, so the truncation is safe
                bytes_left_next = sig_byte[BW-1:0];
                pad_cnt_next    = pad_len[BW-1:0];
                drop_next       = 1'b0;
            end
        end

        if (cmd.drop_clear)
        begin
            drop_next = 1'b0;
        end

        if (cmd.pad_emit)
        begin
            pad_cnt_next = pad_cnt_reg - BW'(1);
        end

        if (cmd.val_emit && bytes_left_reg != '0)
        begin
            bytes_left_next = bytes_left_reg - BW'(1);
        end

        if (emit_data)
        begin
            ovalid_next = 1'b1;
            obyte_next  = cmd.val_emit ? sig_byte : '0;
            oindex_next = pos_reg[RAW_INDEX_W-1:0];
            olast_next  = pos_reg == POS_LAST;
            oerr_next   = 1'b0;
            pos_next    = pos_reg + PW'(1);
        end
        else if (cmd.err_emit)
        begin
            ovalid_next = 1'b1;
            obyte_next  = '0;
            oindex_next = '0;
            olast_next  = 1'b0;
            oerr_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            pad_cnt_reg    <= '0;
            drop_reg       <= 1'b0;
            pos_reg        <= '0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            bytes_left_reg <= bytes_left_next;
            pad_cnt_reg    <= pad_cnt_next;
            drop_reg       <= drop_next;
            pos_reg        <= pos_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obyte_reg  <= obyte_next;
        oindex_reg <= oindex_next;
        olast_reg  <= olast_next;
        oerr_reg   <= oerr_next;
    end

    assign out_valid    = ovalid_reg;
    assign raw_byte     = obyte_reg;
    assign raw_index    = oindex_reg;
    assign last_out     = olast_reg;
    assign length_error = oerr_reg;

endmodule

/* hdl/der_ecdsa_sig_to_raw_core.sv */
// ----------------------------------------------------------------------------
// der_ecdsa_sig_to_raw_core
// DER ECDSA signature to fixed raw r||s byte stream converter.
// ----------------------------------------------------------------------------
// Feed the DER signature one byte per word on sig_in, with first_byte set on
// the sequence tag; raw_out then carries the 2*COMPONENT_BYTES raw bytes, r
// then s, each with its index and last_out on the final one. An integer
// length L below COMPONENT_BYTES adds COMPONENT_BYTES-L zero pad words, for
// which sig_in is held off while they go out one per cycle through the
// single output register, whenever that register is free.
// An integer length above COMPONENT_BYTES+1 gives one word with
// length_error set, and input is then ignored until the next first byte.
module der_ecdsa_sig_to_raw_core
    import dsr_pkg::*;
#(
    parameter int COMPONENT_BYTES = COMPONENT_BYTES_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    dsr_sig_if.sink   sig_in,
    dsr_raw_if.source raw_out
);

    dsr_cmd_t    cmd;
    dsr_status_t status;

    dsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sig_in.valid),
        .in_first (sig_in.first_byte),
        .in_ready (sig_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    dsr_datapath #(
        .COMPONENT_BYTES (COMPONENT_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .sig_byte     (sig_in.sig_byte),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (raw_out.valid),
        .out_ready    (raw_out.ready),
        .raw_byte     (raw_out.raw_byte),
        .raw_index    (raw_out.raw_index),
        .last_out     (raw_out.last_out),
        .length_error (raw_out.length_error)
    );

endmodule

/* tb/der_ecdsa_sig_to_raw_core_tb.sv */
// ----------------------------------------------------------------------------
// der_ecdsa_sig_to_raw_core_tb
// Self-checking bench for the DER to raw r||s converter. DER signatures, cut
// signatures and noise go in one byte per word. An in-bench parser model
// predicts every raw word, and each raw word is compared field by field in
// order. Both sides stall at random, except in the full-rate test.
// ----------------------------------------------------------------------------
module der_ecdsa_sig_to_raw_core_tb;
    import dsr_pkg::*;

    localparam int CB         = COMPONENT_BYTES_DEF;
    localparam int RAW_LAST   = 2 * CB - 1;
    localparam int DRAIN_CYC  = 40;
    localparam int PRINT_MAX  = 30;

    localparam logic [7:0] TAG_SEQ = 8'h30;
    localparam logic [7:0] TAG_INT = 8'h02;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEQ_LEN,
        ST_R_TAG,
        ST_R_LEN,
        ST_R_VAL,
        ST_S_TAG,
        ST_S_LEN,
        ST_S_VAL
    } parse_st_t;

    typedef struct packed {
        logic [SIG_BYTE_W-1:0]  data;
        logic [RAW_INDEX_W-1:0] idx;
        logic                   last;
        logic                   err;
    } raw_word_t;

    logic clk;
    logic rst_n;

    dsr_sig_if sig_in ();
    dsr_raw_if raw_out ();

    der_ecdsa_sig_to_raw_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sig_in  (sig_in),
        .raw_out (raw_out)
    );

    // parser model state
    parse_st_t prs_state;
    int        val_left;
    logic      drop_lead;
    int        raw_pos;

    raw_word_t raw_expect_q[$];

    int send_idle_pct;
    int recv_idle_pct;
    int words_sent;
    int words_checked;
    int sigs_sent;
    int mismatch_count;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_MAX)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic push_raw(input logic [7:0] b);
        raw_word_t w;
        w.data = b;
        w.idx  = raw_pos[RAW_INDEX_W-1:0];
        w.last = (raw_pos == RAW_LAST);
        w.err  = 1'b0;
        raw_expect_q.push_back(w);
        raw_pos++;
    endtask

    task automatic take_len(input logic [7:0] len, input parse_st_t val_st,
                            input parse_st_t next_st);
        raw_word_t w;
        if (len > CB + 1)
        begin
            w = '0;
            w.err = 1'b1;
            raw_expect_q.push_back(w);
            prs_state = ST_IDLE;
            val_left  = 0;
            drop_lead = 1'b0;
        end
        else if (len == CB + 1)
        begin
            drop_lead = 1'b1;
            val_left  = CB;
            prs_state = val_st;
        end
        else
        begin
            for (int i = int'(len); i < CB; i++)
                push_raw(8'h00);
            drop_lead = 1'b0;
            val_left  = len;
            prs_state = (len != 0) ? val_st : next_st;
        end
    endtask

    task automatic take_val(input logic [7:0] b, input parse_st_t next_st);
        if (drop_lead)
            drop_lead = 1'b0;
        else
        begin
            push_raw(b);
            if (val_left > 0)
                val_left--;
            if (val_left == 0)
                prs_state = next_st;
        end
    endtask

    task automatic predict_raw(input logic [7:0] b, input logic first_flag);
        if (first_flag)
        begin
            prs_state = ST_SEQ_LEN;
            val_left  = 0;
            drop_lead = 1'b0;
            raw_pos   = 0;
        end
        else
        begin
            case (prs_state)
                ST_SEQ_LEN: prs_state = ST_R_TAG;
                ST_R_TAG:   prs_state = ST_R_LEN;
                ST_R_LEN:   take_len(b, ST_R_VAL, ST_S_TAG);
                ST_R_VAL:   take_val(b, ST_S_TAG);
                ST_S_TAG:   prs_state = ST_S_LEN;
                ST_S_LEN:   take_len(b, ST_S_VAL, ST_IDLE);
                ST_S_VAL:   take_val(b, ST_IDLE);
                default:    ;
            endcase
        end
    endtask

    // Called at a rising edge; returns at the edge where the word was taken.
    task automatic send_word(input logic [7:0] b, input logic first_flag);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sig_in.valid <= 1'b0;
            @(posedge clk);
        end
        sig_in.valid      <= 1'b1;
        sig_in.sig_byte   <= b;
        sig_in.first_byte <= first_flag;
        do
            @(posedge clk);
        while (!(sig_in.valid && sig_in.ready));
        predict_raw(b, first_flag);
        words_sent++;
    endtask

    task automatic add_component(ref logic [8:0] wq[$], input logic [7:0] len);
        int n_val;
        n_val = (len <= CB) ? int'(len) : 0;
        wq.push_back({1'b0, TAG_INT});
        wq.push_back({1'b0, len});
        // sign-padding byte, then a full component
        if (len == CB + 1)
        begin
            wq.push_back({1'b0, ($urandom_range(1) != 0) ? 8'h00 : 8'($urandom)});
            n_val = CB;
        end
        for (int i = 0; i < n_val; i++)
            wq.push_back({1'b0, 8'($urandom)});
    endtask

    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return 8'(CB);
        else if (r < 55)
            return 8'(CB + 1);
        else if (r < 88)
            return 8'($urandom_range(CB - 1, 0));
        else
            return 8'($urandom_range(255, CB + 2));
    endfunction

    // One DER signature; cut_at >= 0 truncates it so the next word restarts.
    task automatic send_signature(input int cut_at);
        logic [8:0] wq[$];
        logic [7:0] r_len;
        int         n;
        r_len = pick_len();
        wq.push_back({1'b1, TAG_SEQ});
        wq.push_back({1'b0, 8'($urandom)});
        add_component(wq, r_len);
        if (r_len <= CB + 1)
            add_component(wq, pick_len());
        n = $urandom_range(2);
        for (int i = 0; i < n; i++)
            wq.push_back({1'b0, 8'($urandom)});
        if (cut_at >= 0 && cut_at < wq.size())
            wq = wq[0:cut_at];
        foreach (wq[i])
            send_word(wq[i][7:0], wq[i][8]);
        sigs_sent++;
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++)
            send_word(8'($urandom), $urandom_range(3) == 0);
    endtask

    task automatic run_mix(input int n_words);
        int start;
        int r;
        start = words_sent;
        while (words_sent - start < n_words)
        begin
            r = $urandom_range(99);
            if (r < 80)
                send_signature(-1);
            else if (r < 90)
                send_signature($urandom_range(40, 1));
            else
                send_noise();
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 15;
        recv_idle_pct = 52;
        // stray byte before any tag
        send_word(8'hFF, 1'b0);
        // zero-length r, one-byte s, then a trailing byte
        send_word(TAG_SEQ, 1'b1);
        send_word(8'h44, 1'b0);
        send_word(TAG_INT, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(TAG_INT, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        // r length just past the limit, then ignored junk
        send_word(TAG_SEQ, 1'b1);
        send_word(8'h46, 1'b0);
        send_word(TAG_INT, 1'b0);
        send_word(8'(CB + 2), 1'b0);
        send_word(8'h5A, 1'b0);
        // padded r: sign byte dropped, restart in the middle of the value
        send_word(TAG_SEQ, 1'b1);
        send_word(8'h45, 1'b0);
        send_word(TAG_INT, 1'b0);
        send_word(8'(CB + 1), 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hAB, 1'b0);
        // one-byte r, s length at maximum byte value
        send_word(TAG_SEQ, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(TAG_INT, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(TAG_INT, 1'b0);
        send_word(8'hFF, 1'b0);
    endtask

    task automatic test_busy_sink();
        send_idle_pct = 15;
        recv_idle_pct = 52;
        run_mix(110);
    endtask

    task automatic test_busy_source();
        send_idle_pct = 52;
        recv_idle_pct = 15;
        run_mix(110);
    endtask

    task automatic test_full_rate();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_mix(110);
    endtask

    task automatic check_raw_word();
        raw_word_t exp_w;
        if (raw_expect_q.size() == 0)
        begin
            report_mismatch($sformatf("raw word %02h idx %0d with none expected",
                                      raw_out.raw_byte, raw_out.raw_index));
            return;
        end
        exp_w = raw_expect_q.pop_front();
        words_checked++;
        if (raw_out.raw_byte !== exp_w.data)
            report_mismatch($sformatf("raw_byte %02h, expected %02h (idx %0d)",
                                      raw_out.raw_byte, exp_w.data, exp_w.idx));
        if (raw_out.raw_index !== exp_w.idx)
            report_mismatch($sformatf("raw_index %0d, expected %0d",
                                      raw_out.raw_index, exp_w.idx));
        if (raw_out.last_out !== exp_w.last)
            report_mismatch($sformatf("last_out %b, expected %b (idx %0d)",
                                      raw_out.last_out, exp_w.last, exp_w.idx));
        if (raw_out.length_error !== exp_w.err)
            report_mismatch($sformatf("length_error %b, expected %b",
                                      raw_out.length_error, exp_w.err));
    endtask

    // output side: check, then pick ready for the next cycle
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && raw_out.valid && raw_out.ready)
                check_raw_word();
            raw_out.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #12_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        sig_in.valid      = 1'b0;
        sig_in.sig_byte   = '0;
        sig_in.first_byte = 1'b0;
        raw_out.ready     = 1'b0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        words_sent        = 0;
        words_checked     = 0;
        sigs_sent         = 0;
        mismatch_count    = 0;
        prs_state         = ST_IDLE;
        val_left          = 0;
        drop_lead         = 1'b0;
        raw_pos           = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_busy_sink();
        test_busy_source();
        test_full_rate();

        sig_in.valid <= 1'b0;
        while (raw_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("covered %0d input words (%0d random signatures), %0d raw words checked",
                 words_sent, sigs_sent, words_checked);
        $display("stall mixes: sink-heavy, source-heavy, none; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
hdl/dsr_pkg.sv
hdl/dsr_sig_if.sv
hdl/dsr_raw_if.sv
hdl/dsr_ctrl.sv
hdl/dsr_datapath.sv
hdl/der_ecdsa_sig_to_raw_core.sv
tb/der_ecdsa_sig_to_raw_core_tb.sv
